FILE: rtl/sle_pkg.sv
// ----------------------------------------------------------------------------
// sle_pkg
// Shared types and constants for the sequential list engine.
// ----------------------------------------------------------------------------
package sle_pkg;

  localparam int DEPTH = 64;
  localparam int AW    = 6;
  localparam int LW    = 7;
  localparam int VW    = 16;

  localparam logic [3:0] MD_APPEND   = 4'd0;
  localparam logic [3:0] MD_CLEAR    = 4'd1;
  localparam logic [3:0] MD_READ     = 4'd2;
  localparam logic [3:0] MD_SEARCH   = 4'd3;
  localparam logic [3:0] MD_INSERT   = 4'd4;
  localparam logic [3:0] MD_DELPOS   = 4'd5;
  localparam logic [3:0] MD_DELVAL   = 4'd6;
  localparam logic [3:0] MD_DEDUP    = 4'd7;
  localparam logic [3:0] MD_REVERSE  = 4'd8;
  localparam logic [3:0] MD_SORTUP   = 4'd9;
  localparam logic [3:0] MD_SORTDOWN = 4'd10;
  localparam logic [3:0] MD_PARTN    = 4'd11;
  localparam logic [3:0] MD_MAXRUN   = 4'd12;
  localparam logic [3:0] MD_DUMP     = 4'd13;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NOTFOUND = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_BADPOS   = 3'd3;
  localparam logic [2:0] ST_EMPTY    = 3'd4;

  typedef struct packed {
    logic [VW-1:0] data;
    logic [AW-1:0] idx;
    logic [2:0]    status;
    logic [LW-1:0] count;
    logic          last;
  } res_t;

  function automatic res_t mk_res(logic [VW-1:0] data, logic [AW-1:0] idx,
                                  logic [2:0] status, logic last);
    res_t r;
    r.data   = data;
    r.idx    = idx;
    r.status = status;
    r.count  = '0;
    r.last   = last;
    return r;
  endfunction

endpackage

FILE: rtl/sequential_list_engine_core.sv
// ----------------------------------------------------------------------------
// sequential_list_engine_core
// List of signed words in a single-port-read memory, driven by a sequencer.
// ----------------------------------------------------------------------------
// One request is taken at a time; in_tready is high only while the engine is
// idle. Scans (search, dump, delete, reverse) step through the list entry by
// entry; dump and search can also be held by output stalls. Selection sort
// reads one entry a cycle through the memory read port in its inner scan.
// Remove duplicates is quadratic in the number of entries.
// ----------------------------------------------------------------------------
module sequential_list_engine_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // value[15:0], location[22:16], end_location[29:23]
  input  logic [3:0]  in_tuser,   // mode[3:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // data[15:0], index[21:16], count[28:22]
  output logic [2:0]  out_tuser,  // status[2:0]
  output logic        out_tlast
);

  localparam int AW = sle_pkg::AW;
  localparam int LW = sle_pkg::LW;
  localparam int VW = sle_pkg::VW;

  typedef enum logic [28:0] {
    S_IDLE    = 29'd1 << 0,
    S_DISP    = 29'd1 << 1,
    S_EMIT    = 29'd1 << 2,
    S_RD1     = 29'd1 << 3,
    S_SR_ISS  = 29'd1 << 4,
    S_SR_CHK  = 29'd1 << 5,
    S_INS_ISS = 29'd1 << 6,
    S_INS_WR  = 29'd1 << 7,
    S_DP_GONE = 29'd1 << 8,
    S_DP_ISS  = 29'd1 << 9,
    S_DP_WR   = 29'd1 << 10,
    S_DV_ISS  = 29'd1 << 11,
    S_DV_CHK  = 29'd1 << 12,
    S_DD_ISS  = 29'd1 << 13,
    S_DD_HOLD = 29'd1 << 14,
    S_DD_RISS = 29'd1 << 15,
    S_DD_RCHK = 29'd1 << 16,
    S_RV_A    = 29'd1 << 17,
    S_RV_B    = 29'd1 << 18,
    S_RV_C    = 29'd1 << 19,
    S_RV_D    = 29'd1 << 20,
    S_SO_OUT  = 29'd1 << 21,
    S_SO_HEAD = 29'd1 << 22,
    S_SO_SCAN = 29'd1 << 23,
    S_SO_SW1  = 29'd1 << 24,
    S_SO_SW2  = 29'd1 << 25,
    S_SO_FIN  = 29'd1 << 26,
    S_MR_ISS  = 29'd1 << 27,
    S_MR_CHK  = 29'd1 << 28
  } state_t;

  state_t        state_r, state_nxt, ret_r, ret_nxt;
  logic [3:0]    op_r, op_nxt;
  logic [VW-1:0] val_r, val_nxt;
  logic [LW-1:0] loc_r, loc_nxt, end_r, end_nxt;
  logic [LW-1:0] len_r, len_nxt;
  logic [LW-1:0] p_r, p_nxt, q_r, q_nxt, r_r, r_nxt, hi_r, hi_nxt;
  logic [AW-1:0] pick_r, pick_nxt;
  logic [VW-1:0] pickv_r, pickv_nxt, pv_r, pv_nxt;
  logic          up_r, up_nxt, stage_r, stage_nxt;
  logic          rv_r, rv_nxt;
  logic [AW-1:0] ra_r, ra_nxt;
  logic          pend_r, pend_nxt;
  logic [AW-1:0] pend_i_r, pend_i_nxt;
  logic [LW-1:0] cs_r, cs_nxt, cl_r, cl_nxt, bs_r, bs_nxt, bl_r, bl_nxt;
  logic [VW-1:0] cv_r, cv_nxt, bv_r, bv_nxt;
  sle_pkg::res_t res_r, res_nxt, res_out;

  logic [VW-1:0] mem [sle_pkg::DEPTH];
  logic [VW-1:0] rdata_r;
  logic          we;
  logic [AW-1:0] wa, rda;
  logic [VW-1:0] wd;

  logic          load, can_load;
  logic [LW-1:0] p_inc, half, mirror;
  logic          better, close_run;
  logic [LW-1:0] fbl, fbs;
  logic [VW-1:0] fbv;

  assign in_tready = (state_r == S_IDLE);
  assign p_inc     = p_r + LW'(1);
  assign half      = len_r >> 1;
  assign mirror    = len_r - LW'(1) - p_r;
  assign better    = up_r ? ($signed(rdata_r) < $signed(pickv_r))
                          : ($signed(rdata_r) > $signed(pickv_r));
  assign close_run = (cl_r >= LW'(2)) && (cl_r > bl_r);
  assign fbl       = close_run ? cl_r : bl_r;
  assign fbs       = close_run ? cs_r : bs_r;
  assign fbv       = close_run ? cv_r : bv_r;

  always_comb begin
    res_out       = res_r;
    res_out.count = len_r;
  end

  always_comb begin
    state_nxt = state_r;  ret_nxt = ret_r;    op_nxt = op_r;
    val_nxt = val_r;      loc_nxt = loc_r;    end_nxt = end_r;
    len_nxt = len_r;      p_nxt = p_r;        q_nxt = q_r;
    r_nxt = r_r;          hi_nxt = hi_r;      pick_nxt = pick_r;
    pickv_nxt = pickv_r;  pv_nxt = pv_r;      up_nxt = up_r;
    stage_nxt = stage_r;  rv_nxt = 1'b0;      ra_nxt = ra_r;
    pend_nxt = pend_r;    pend_i_nxt = pend_i_r;
    cs_nxt = cs_r;        cl_nxt = cl_r;      bs_nxt = bs_r;
    bl_nxt = bl_r;        cv_nxt = cv_r;      bv_nxt = bv_r;
    res_nxt = res_r;
    we = 1'b0;  wa = '0;  wd = '0;  rda = '0;  load = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          op_nxt    = in_tuser;
          val_nxt   = in_tdata[15:0];
          loc_nxt   = in_tdata[22:16];
          end_nxt   = in_tdata[29:23];
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        ret_nxt   = S_IDLE;
        state_nxt = S_EMIT;
        unique case (op_r) inside
          sle_pkg::MD_APPEND: begin
            if (len_r >= LW'(sle_pkg::DEPTH)) begin
              res_nxt = sle_pkg::mk_res(val_r, '0, sle_pkg::ST_FULL, 1'b1);
            end else begin
              we = 1'b1;  wa = len_r[AW-1:0];  wd = val_r;
              len_nxt = len_r + LW'(1);
              res_nxt = sle_pkg::mk_res(val_r, len_r[AW-1:0], sle_pkg::ST_OK, 1'b1);
            end
          end
          sle_pkg::MD_CLEAR: begin
            len_nxt = '0;
            res_nxt = sle_pkg::mk_res('0, '0, sle_pkg::ST_OK, 1'b1);
          end
          sle_pkg::MD_READ: begin
            if (loc_r >= len_r) begin
              res_nxt = sle_pkg::mk_res('0, '0, sle_pkg::ST_BADPOS, 1'b1);
            end else begin
              rda = loc_r[AW-1:0];
              state_nxt = S_RD1;
            end
          end
          sle_pkg::MD_SEARCH: begin
            p_nxt = '0;  pend_nxt = 1'b0;
            state_nxt = S_SR_ISS;
          end
          sle_pkg::MD_INSERT: begin
            if (len_r >= LW'(sle_pkg::DEPTH)) begin
              res_nxt = sle_pkg::mk_res(val_r, '0, sle_pkg::ST_FULL, 1'b1);
            end else if (loc_r > len_r) begin
              res_nxt = sle_pkg::mk_res(val_r, '0, sle_pkg::ST_BADPOS, 1'b1);
            end else begin
              p_nxt = len_r;
              state_nxt = S_INS_ISS;
            end
          end
          sle_pkg::MD_DELPOS: begin
            if (loc_r >= len_r) begin
              res_nxt = sle_pkg::mk_res('0, '0, sle_pkg::ST_BADPOS, 1'b1);
            end else begin
              rda = loc_r[AW-1:0];
              state_nxt = S_DP_GONE;
            end
          end
          sle_pkg::MD_DELVAL: begin
            p_nxt = '0;  q_nxt = '0;
            state_nxt = S_DV_ISS;
          end
          sle_pkg::MD_DEDUP: begin
            p_nxt = '0;  q_nxt = '0;
            state_nxt = S_DD_ISS;
          end
          sle_pkg::MD_REVERSE: begin
            p_nxt = '0;
            state_nxt = S_RV_A;
          end
          sle_pkg::MD_SORTUP, sle_pkg::MD_SORTDOWN: begin
            if (loc_r > end_r || end_r > len_r) begin
              res_nxt = sle_pkg::mk_res('0, '0, sle_pkg::ST_BADPOS, 1'b1);
            end else begin
              p_nxt = loc_r;  hi_nxt = end_r;
              up_nxt = (op_r == sle_pkg::MD_SORTUP);
              state_nxt = S_SO_OUT;
            end
          end
          sle_pkg::MD_PARTN: begin
            if (loc_r >= len_r) begin
              res_nxt = sle_pkg::mk_res('0, '0, sle_pkg::ST_BADPOS, 1'b1);
            end else begin
              p_nxt = loc_r + LW'(1);  hi_nxt = len_r;
              up_nxt = 1'b0;  stage_nxt = 1'b0;
              state_nxt = S_SO_OUT;
            end
          end
          sle_pkg::MD_MAXRUN: begin
            p_nxt = '0;  hi_nxt = len_r;  up_nxt = 1'b1;
            state_nxt = S_SO_OUT;
          end
          sle_pkg::MD_DUMP: begin
            if (len_r == '0) begin
              res_nxt = sle_pkg::mk_res('0, '0, sle_pkg::ST_EMPTY, 1'b1);
            end else begin
              p_nxt = '0;
              rda = '0;
              state_nxt = S_SR_CHK;
            end
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_EMIT: begin
        // keep the next dump entry on the read port while the word waits
        rda = p_r[AW-1:0];
        load = 1'b1;
        if (can_load) begin
          state_nxt = ret_r;
        end
      end
      S_RD1: begin
        res_nxt = sle_pkg::mk_res(rdata_r, loc_r[AW-1:0], sle_pkg::ST_OK, 1'b1);
        ret_nxt = S_IDLE;  state_nxt = S_EMIT;
      end
      S_SR_ISS: begin
        if (p_r < len_r) begin
          rda = p_r[AW-1:0];
          state_nxt = S_SR_CHK;
        end else begin
          ret_nxt = S_IDLE;  state_nxt = S_EMIT;
          if (pend_r) begin
            res_nxt = sle_pkg::mk_res(val_r, pend_i_r, sle_pkg::ST_OK, 1'b1);
          end else begin
            res_nxt = sle_pkg::mk_res(val_r, '0, sle_pkg::ST_NOTFOUND, 1'b1);
          end
        end
      end
      S_SR_CHK: begin
        // shared by search (hold one match back to mark the last) and dump
        p_nxt = p_inc;
        if (op_r == sle_pkg::MD_DUMP) begin
          res_nxt = sle_pkg::mk_res(rdata_r, p_r[AW-1:0], sle_pkg::ST_OK,
                                    p_inc == len_r);
          ret_nxt = (p_inc == len_r) ? S_IDLE : S_SR_CHK;
          rda = p_inc[AW-1:0];
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_SR_ISS;
          if (rdata_r == val_r) begin
            pend_nxt = 1'b1;  pend_i_nxt = p_r[AW-1:0];
            if (pend_r) begin
              res_nxt = sle_pkg::mk_res(val_r, pend_i_r, sle_pkg::ST_OK, 1'b0);
              ret_nxt = S_SR_ISS;  state_nxt = S_EMIT;
            end
          end
        end
      end
      S_INS_ISS: begin
        if (p_r > loc_r) begin
          rda = p_r[AW-1:0] - AW'(1);
          state_nxt = S_INS_WR;
        end else begin
          we = 1'b1;  wa = loc_r[AW-1:0];  wd = val_r;
          len_nxt = len_r + LW'(1);
          res_nxt = sle_pkg::mk_res(val_r, loc_r[AW-1:0], sle_pkg::ST_OK, 1'b1);
          ret_nxt = S_IDLE;  state_nxt = S_EMIT;
        end
      end
      S_INS_WR: begin
        we = 1'b1;  wa = p_r[AW-1:0];  wd = rdata_r;
        p_nxt = p_r - LW'(1);
        state_nxt = S_INS_ISS;
      end
      S_DP_GONE: begin
        pv_nxt = rdata_r;  p_nxt = loc_r;
        state_nxt = S_DP_ISS;
      end
      S_DP_ISS: begin
        if (p_inc < len_r) begin
          rda = p_inc[AW-1:0];
          state_nxt = S_DP_WR;
        end else begin
          len_nxt = len_r - LW'(1);
          res_nxt = sle_pkg::mk_res(pv_r, loc_r[AW-1:0], sle_pkg::ST_OK, 1'b1);
          ret_nxt = S_IDLE;  state_nxt = S_EMIT;
        end
      end
      S_DP_WR: begin
        we = 1'b1;  wa = p_r[AW-1:0];  wd = rdata_r;
        p_nxt = p_inc;
        state_nxt = S_DP_ISS;
      end
      S_DV_ISS: begin
        if (p_r < len_r) begin
          rda = p_r[AW-1:0];
          state_nxt = S_DV_CHK;
        end else begin
          len_nxt = q_r;
          res_nxt = sle_pkg::mk_res(val_r, '0, (q_r == len_r) ? sle_pkg::ST_NOTFOUND
                                                             : sle_pkg::ST_OK, 1'b1);
          ret_nxt = S_IDLE;  state_nxt = S_EMIT;
        end
      end
      S_DV_CHK: begin
        if (rdata_r != val_r) begin
          we = 1'b1;  wa = q_r[AW-1:0];  wd = rdata_r;
          q_nxt = q_r + LW'(1);
        end
        p_nxt = p_inc;
        state_nxt = S_DV_ISS;
      end
      S_DD_ISS: begin
        if (p_r < len_r) begin
          rda = p_r[AW-1:0];
          state_nxt = S_DD_HOLD;
        end else begin
          len_nxt = q_r;
          res_nxt = sle_pkg::mk_res('0, '0, sle_pkg::ST_OK, 1'b1);
          ret_nxt = S_IDLE;  state_nxt = S_EMIT;
        end
      end
      S_DD_HOLD: begin
        pv_nxt = rdata_r;  r_nxt = '0;
        state_nxt = S_DD_RISS;
      end
      S_DD_RISS: begin
        if (r_r < q_r) begin
          rda = r_r[AW-1:0];
          state_nxt = S_DD_RCHK;
        end else begin
          we = 1'b1;  wa = q_r[AW-1:0];  wd = pv_r;
          q_nxt = q_r + LW'(1);  p_nxt = p_inc;
          state_nxt = S_DD_ISS;
        end
      end
      S_DD_RCHK: begin
        if (rdata_r == pv_r) begin
          p_nxt = p_inc;
          state_nxt = S_DD_ISS;
        end else begin
          r_nxt = r_r + LW'(1);
          state_nxt = S_DD_RISS;
        end
      end
      S_RV_A: begin
        if (p_r < half) begin
          rda = p_r[AW-1:0];
          state_nxt = S_RV_B;
        end else begin
          res_nxt = sle_pkg::mk_res('0, '0, sle_pkg::ST_OK, 1'b1);
          ret_nxt = S_IDLE;  state_nxt = S_EMIT;
        end
      end
      S_RV_B: begin
        pv_nxt = rdata_r;
        rda = mirror[AW-1:0];
        state_nxt = S_RV_C;
      end
      S_RV_C: begin
        we = 1'b1;  wa = p_r[AW-1:0];  wd = rdata_r;
        state_nxt = S_RV_D;
      end
      S_RV_D: begin
        we = 1'b1;  wa = mirror[AW-1:0];  wd = pv_r;
        p_nxt = p_inc;
        state_nxt = S_RV_A;
      end
      S_SO_OUT: begin
        if (p_inc < hi_r) begin
          rda = p_r[AW-1:0];
          state_nxt = S_SO_HEAD;
        end else begin
          state_nxt = S_SO_FIN;
        end
      end
      S_SO_HEAD: begin
        pv_nxt = rdata_r;  pickv_nxt = rdata_r;
        pick_nxt = p_r[AW-1:0];  q_nxt = p_inc;
        state_nxt = S_SO_SCAN;
      end
      S_SO_SCAN: begin
        // one read issued and one compare retired per cycle
        if (q_r < hi_r) begin
          rda = q_r[AW-1:0];
          rv_nxt = 1'b1;  ra_nxt = q_r[AW-1:0];
          q_nxt = q_r + LW'(1);
        end else if (!rv_r) begin
          state_nxt = S_SO_SW1;
        end
        if (rv_r && better) begin
          pick_nxt = ra_r;  pickv_nxt = rdata_r;
        end
      end
      S_SO_SW1: begin
        we = 1'b1;  wa = p_r[AW-1:0];  wd = pickv_r;
        state_nxt = S_SO_SW2;
      end
      S_SO_SW2: begin
        we = 1'b1;  wa = pick_r;  wd = pv_r;
        p_nxt = p_inc;
        state_nxt = S_SO_OUT;
      end
      S_SO_FIN: begin
        if (op_r == sle_pkg::MD_MAXRUN) begin
          p_nxt = '0;  cl_nxt = '0;  bl_nxt = '0;
          state_nxt = S_MR_ISS;
        end else if (op_r == sle_pkg::MD_PARTN && !stage_r) begin
          stage_nxt = 1'b1;  p_nxt = '0;  hi_nxt = loc_r;  up_nxt = 1'b1;
          state_nxt = S_SO_OUT;
        end else begin
          res_nxt = sle_pkg::mk_res('0, '0, sle_pkg::ST_OK, 1'b1);
          ret_nxt = S_IDLE;  state_nxt = S_EMIT;
        end
      end
      S_MR_ISS: begin
        if (p_r < len_r) begin
          rda = p_r[AW-1:0];
          state_nxt = S_MR_CHK;
        end else begin
          if (fbl == '0) begin
            res_nxt = sle_pkg::mk_res('0, '0, sle_pkg::ST_EMPTY, 1'b1);
          end else begin
            res_nxt = sle_pkg::mk_res(fbv, fbs[AW-1:0], sle_pkg::ST_OK, 1'b1);
          end
          ret_nxt = S_IDLE;  state_nxt = S_EMIT;
        end
      end
      S_MR_CHK: begin
        if (cl_r != '0 && rdata_r == cv_r) begin
          cl_nxt = cl_r + LW'(1);
        end else begin
          bl_nxt = fbl;  bs_nxt = fbs;  bv_nxt = fbv;
          cs_nxt = p_r;  cl_nxt = LW'(1);  cv_nxt = rdata_r;
        end
        p_nxt = p_inc;
        state_nxt = S_MR_ISS;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rdata_r <= mem[rda];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ret_r   <= S_IDLE;
      len_r   <= '0;
      rv_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      len_r   <= len_nxt;
      rv_r    <= rv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;     val_r   <= val_nxt;   loc_r  <= loc_nxt;
    end_r    <= end_nxt;    p_r     <= p_nxt;     q_r    <= q_nxt;
    r_r      <= r_nxt;      hi_r    <= hi_nxt;    pick_r <= pick_nxt;
    pickv_r  <= pickv_nxt;  pv_r    <= pv_nxt;    up_r   <= up_nxt;
    stage_r  <= stage_nxt;  ra_r    <= ra_nxt;    pend_r <= pend_nxt;
    pend_i_r <= pend_i_nxt; cs_r    <= cs_nxt;    cl_r   <= cl_nxt;
    bs_r     <= bs_nxt;     bl_r    <= bl_nxt;    cv_r   <= cv_nxt;
    bv_r     <= bv_nxt;     res_r   <= res_nxt;
  end

  sle_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (load),
    .res        (res_out),
    .can_load   (can_load),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

FILE: rtl/sle_out_reg.sv
// ----------------------------------------------------------------------------
// sle_out_reg
// Result holding register between the sequencer and the master stream port.
// ----------------------------------------------------------------------------
module sle_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  sle_pkg::res_t     res,
  output logic              can_load,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [31:0]       out_tdata,  // data[15:0], index[21:16], count[28:22]
  output logic [2:0]        out_tuser,  // status[2:0]
  output logic              out_tlast
);

  logic          valid_r, valid_nxt;
  sle_pkg::res_t hold_r;

  assign can_load = !valid_r || out_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (load && can_load) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && can_load) begin
      hold_r <= res;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {3'd0, hold_r.count, hold_r.idx, hold_r.data};
  assign out_tuser  = hold_r.status;
  assign out_tlast  = hold_r.last;

endmodule

FILE: rtl/sle_checker.sv
// ----------------------------------------------------------------------------
// sle_port_checks
// Port-level checks for the sequential list engine, bound to the top level.
// ----------------------------------------------------------------------------
module sle_port_checks (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [2:0]  out_tuser,
  input logic        out_tlast
);

  a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("request taken while busy");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=>
      (out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast)))
    else $error("stalled result word changed");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[28:22] <= sle_pkg::LW'(sle_pkg::DEPTH)))
    else $error("count beyond depth");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser <= sle_pkg::ST_EMPTY))
    else $error("undefined status");

  a_fail_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser != sle_pkg::ST_OK) |-> out_tlast)
    else $error("failed request not closed");

endmodule

bind sequential_list_engine_core sle_port_checks u_sle_port_checks (.*);
